/* design/pli_pkg.sv */
// ---------------------------------------------------------------------------
// pli_pkg
// shared types and constants for the piecewise linear interpolator
// ---------------------------------------------------------------------------
`default_nettype none
package pli_pkg;
  localparam int MaxNodes = 64;
  localparam int IdxW = $clog2(MaxNodes);
  localparam int CntW = $clog2(MaxNodes + 1);

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_DUP   = 3'd1,
    ST_RANGE = 3'd2,
    ST_EMPTY = 3'd3,
    ST_FULL  = 3'd4
  } status_t;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] result_y;
    logic [6:0]         nodes_held;
  } out_beat_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LSCAN, S_LSHIFT, S_LWRITE, S_QFIRST, S_QLAST, S_QSCAN,
    S_QNEXT, S_QMUL, S_QDIV, S_QFIN, S_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;
endpackage
`default_nettype wire

/* design/pli_divider.sv */
// ---------------------------------------------------------------------------
// pli_divider
// restoring divider, unsigned 64 by 32, one quotient bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none
module pli_divider (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pli_pkg::div_req_t req,
  output logic                  busy,
  output logic [63:0]           quotient
);
  import pli_pkg::*;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic [6:0]  cnt;
  logic [32:0] trial;
  logic [32:0] shifted;

  assign shifted = {rem[31:0], quotient[63]};
  assign trial = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt <= 7'd64;
      rem <= '0;
      dvs <= req.divisor;
      quotient <= req.dividend;
    end else if (busy) begin
      if (trial[32]) begin
        rem <= shifted;
        quotient <= {quotient[62:0], 1'b0};
      end else begin
        rem <= trial;
        quotient <= {quotient[62:0], 1'b1};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

/* design/piecewise_linear_interpolator_top.sv */
// ---------------------------------------------------------------------------
// piecewise_linear_interpolator_top
// sorted node table with linear interpolation between neighbouring nodes
// ---------------------------------------------------------------------------
// channel | direction | handshake    | payload
// in      | input     | valid, stall | in_beat_t
// out     | output    | valid, stall | out_beat_t
// a load scans the held entries for its slot, then shifts the later ones up; a load
//   to a full table answers without scanning
// a rejected query or one on the last node answers without the divider; an interpolated
//   query scans to its segment, then multiplies and divides in the serial divider
// one beat at a time; in_stall is high from acceptance until the result is taken
// reset clears count and flags; node memory is not cleared
`default_nettype none
module piecewise_linear_interpolator_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire pli_pkg::in_beat_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output pli_pkg::out_beat_t      out_data
);
  import pli_pkg::*;

  logic signed [31:0] mem_x [MaxNodes];
  logic signed [31:0] mem_y [MaxNodes];
  logic [IdxW-1:0]    rd_addr;
  logic signed [31:0] rd_x, rd_y;
  logic               wr_en;
  logic [IdxW-1:0]    wr_addr;
  logic signed [31:0] wr_x, wr_y;

  state_t             state, state_next;
  logic [CntW-1:0]    total;
  logic               dup_seen, qphase;
  in_beat_t           req;
  logic [CntW-1:0]    idx;      // scan pointer
  logic               rd_ok;    // registered read of rd_addr is available
  logic               rd_ok_next;
  logic               dup_hit;
  status_t            st;
  logic signed [31:0] res;
  logic signed [31:0] lo_x, lo_y;
  logic [CntW-1:0]    lo_idx;
  logic               neg;
  logic [31:0]        dxq, dyq, xoff;
  logic [63:0]        prod, mul_out;
  logic               div_start;
  div_req_t           dreq;
  logic               dbusy;
  logic [63:0]        quot;
  logic signed [32:0] dy_full;
  logic               full, lscan_stop, qscan_stop;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
  end

  pli_divider u_div (.clk(clk), .rst(rst), .req(dreq), .busy(dbusy), .quotient(quot));

  assign dreq = '{start: div_start, dividend: prod, divisor: dxq};

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data.status = st;
  assign out_data.result_y = res;
  assign out_data.nodes_held = 7'(total);

  assign full = (total == CntW'(MaxNodes));
  assign lscan_stop = (idx >= total) || (rd_x > req.point_x);
  assign qscan_stop = (idx >= total - 1'b1) || (rd_x > req.point_x);
  assign dy_full = 33'(rd_y) - 33'(lo_y);
  assign xoff = req.point_x - lo_x;
  // both factors fit in 32 bits, the product in 64
  assign mul_out = dyq * xoff;

  always_comb begin
    state_next = state;
    rd_ok_next = 1'b0;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = in_data.req_type ? S_QFIRST : S_LSCAN;
      S_LSCAN: begin
        rd_ok_next = !rd_ok;
        if (full) state_next = S_OUT;
        else if (rd_ok && lscan_stop) state_next = S_LSHIFT;
      end
      S_LSHIFT: begin
        rd_ok_next = !rd_ok;
        if (idx == lo_idx) state_next = S_LWRITE;
      end
      S_LWRITE: state_next = S_OUT;
      S_QFIRST: begin
        rd_ok_next = !rd_ok;
        if (total == '0 || dup_seen) state_next = S_OUT;
        else if (rd_ok) state_next = (req.point_x < rd_x) ? S_OUT : S_QLAST;
      end
      S_QLAST: begin
        rd_ok_next = !rd_ok;
        if (rd_ok) state_next = (req.point_x >= rd_x) ? S_OUT : S_QSCAN;
      end
      S_QSCAN: begin
        rd_ok_next = !rd_ok;
        if (rd_ok && qscan_stop) state_next = S_QNEXT;
      end
      S_QNEXT: begin
        rd_ok_next = !rd_ok;
        if (rd_ok) state_next = S_QMUL;
      end
      S_QMUL:   state_next = S_QDIV;
      S_QDIV:   if (!dbusy && !div_start) state_next = S_QFIN;
      S_QFIN:   state_next = S_OUT;
      S_OUT:    if (!out_stall) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rd_addr = idx[IdxW-1:0];
    if (state == S_LSHIFT) rd_addr = IdxW'(idx - 1'b1);
    if (state == S_QFIRST) rd_addr = '0;
    if (state == S_QLAST)  rd_addr = IdxW'(total - 1'b1);
    if (state == S_QNEXT)  rd_addr = IdxW'(lo_idx + 1'b1);
    wr_en = 1'b0;
    wr_addr = idx[IdxW-1:0];
    wr_x = rd_x;
    wr_y = rd_y;
    if (state == S_LSHIFT && rd_ok && idx != lo_idx) wr_en = 1'b1;
    if (state == S_LWRITE) begin
      wr_en = 1'b1;
      wr_addr = lo_idx[IdxW-1:0];
      wr_x = req.point_x;
      wr_y = req.point_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      total <= '0;
      dup_seen <= 1'b0;
      qphase <= 1'b0;
      rd_ok <= 1'b0;
      div_start <= 1'b0;
    end else begin
      state <= state_next;
      rd_ok <= rd_ok_next;
      div_start <= (state == S_QMUL);
      unique case (state)
        S_IDLE: if (in_valid) begin
          req <= in_data;
          res <= '0;
          idx <= '0;
          dup_hit <= 1'b0;
          qphase <= in_data.req_type;
          if (!in_data.req_type && qphase) begin
            total <= '0;
            dup_seen <= 1'b0;
          end
        end
        S_LSCAN: begin
          if (full) begin
            // full table: drop the node
            st <= ST_FULL;
          end else if (rd_ok) begin
            if (lscan_stop) begin
              lo_idx <= idx;
              idx <= total;
            end else begin
              if (rd_x == req.point_x) dup_hit <= 1'b1;
              idx <= idx + 1'b1;
            end
          end
        end
        S_LSHIFT: if (rd_ok && idx != lo_idx) idx <= idx - 1'b1;
        S_LWRITE: begin
          total <= total + 1'b1;
          st <= dup_hit ? ST_DUP : ST_OK;
          if (dup_hit) dup_seen <= 1'b1;
        end
        S_QFIRST: begin
          if (total == '0) st <= ST_EMPTY;
          else if (dup_seen) st <= ST_DUP;
          else if (rd_ok && req.point_x < rd_x) st <= ST_RANGE;
        end
        S_QLAST: if (rd_ok) begin
          if (req.point_x > rd_x) begin
            st <= ST_RANGE;
          end else if (req.point_x == rd_x) begin
            st <= ST_OK;
            res <= rd_y;
          end
        end
        S_QSCAN: if (rd_ok && !qscan_stop) begin
          lo_idx <= idx;
          lo_x <= rd_x;
          lo_y <= rd_y;
          idx <= idx + 1'b1;
        end
        S_QNEXT: if (rd_ok) begin
          dxq <= rd_x - lo_x;
          neg <= dy_full[32];
          dyq <= dy_full[32] ? 32'(-dy_full) : 32'(dy_full);
        end
        S_QMUL: prod <= mul_out;
        S_QDIV: ;
        S_QFIN: begin
          st <= ST_OK;
          res <= neg ? lo_y - 32'(quot) : lo_y + 32'(quot);
        end
        S_OUT: ;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

/* design/pli_checker.sv */
// ---------------------------------------------------------------------------
// pli_checker
// port level checks for the interpolator
// ---------------------------------------------------------------------------
`default_nettype none
module pli_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire pli_pkg::out_beat_t out_data
);
  import pli_pkg::*;
  // result beat holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out hold");
  // one beat in flight: no input while a result is waiting
  a_one: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(in_valid && !in_stall)) else $error("in taken while out pending");
  // rejected queries and loads carry zero unless ok
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.result_y == '0)
    else $error("nonzero result");
  // node count never exceeds table size
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.nodes_held <= 7'(MaxNodes)) else $error("count");
endmodule
bind piecewise_linear_interpolator_top pli_checker u_chk (.*);
`default_nettype wire
